// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker, mi3_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every rising clock edge out of reset.
`define MI3_ASSERT_ALWAYS(name, clk_s, rstn_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define MI3_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants of the 3x3 matrix inverse: element and column counts,
// operand indices of the nine adjugate cofactors and determinant terms.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int NUM_ELEM = 9;
  localparam int NUM_COL  = 3;

  typedef logic [3:0] idx_t;

  // adj[i] = a[P]*a[Q] - a[S]*a[T], elements indexed row*3+col
  localparam idx_t COF_P [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_Q [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_S [NUM_ELEM] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_T [NUM_ELEM] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

  // determinant by first row: a0*adj0 + a1*adj3 + a2*adj6
  localparam idx_t DET_ADJ [NUM_COL] = '{4'd0, 4'd3, 4'd6};

endpackage

// ===== rtl/mi3_cofactor.sv =====
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: eighteen element products, then the nine exact cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [W-1:0] a [mi3_pkg::NUM_ELEM],
  output logic                out_valid,
  output logic signed [2*W:0] adj [mi3_pkg::NUM_ELEM],
  output logic signed [W-1:0] row [mi3_pkg::NUM_COL]
);

  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 1;

  logic                 v1_r, v2_r;
  logic signed [PW-1:0] pp_r   [mi3_pkg::NUM_ELEM];
  logic signed [PW-1:0] qq_r   [mi3_pkg::NUM_ELEM];
  logic signed [AW-1:0] adj_r  [mi3_pkg::NUM_ELEM];
  logic signed [W-1:0]  row1_r [mi3_pkg::NUM_COL];
  logic signed [W-1:0]  row2_r [mi3_pkg::NUM_COL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
      pp_r[i]  <= a[mi3_pkg::COF_P[i]] * a[mi3_pkg::COF_Q[i]];
      qq_r[i]  <= a[mi3_pkg::COF_S[i]] * a[mi3_pkg::COF_T[i]];
      adj_r[i] <= AW'(pp_r[i]) - AW'(qq_r[i]);
    end
    for (int j = 0; j < mi3_pkg::NUM_COL; j++) begin
      row1_r[j] <= a[j];
      row2_r[j] <= row1_r[j];
    end
  end

  assign out_valid = v2_r;
  assign adj       = adj_r;
  assign row       = row2_r;

endmodule

// ===== rtl/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: split partial products, per-column terms, determinant sum.
// Cofactors travel alongside so they leave aligned with the determinant.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [2*W:0]   adj [mi3_pkg::NUM_ELEM],
  input  logic signed [W-1:0]   row [mi3_pkg::NUM_COL],
  output logic                  out_valid,
  output logic signed [2*W:0]   adj_out [mi3_pkg::NUM_ELEM],
  output logic signed [3*W+2:0] det
);

  localparam int AW  = 2 * W + 1;
  localparam int LPW = 2 * W + 1;
  localparam int DW  = 3 * W + 3;

  logic                  v3_r, v4_r, v5_r;
  logic signed [LPW-1:0] lo_r   [mi3_pkg::NUM_COL];
  logic signed [LPW-1:0] hi_r   [mi3_pkg::NUM_COL];
  logic signed [DW-1:0]  term_r [mi3_pkg::NUM_COL];
  logic signed [DW-1:0]  det_r;
  logic signed [AW-1:0]  adj3_r [mi3_pkg::NUM_ELEM];
  logic signed [AW-1:0]  adj4_r [mi3_pkg::NUM_ELEM];
  logic signed [AW-1:0]  adj5_r [mi3_pkg::NUM_ELEM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < mi3_pkg::NUM_COL; j++) begin
      lo_r[j]   <= row[j] * $signed({1'b0, adj[mi3_pkg::DET_ADJ[j]][W-1:0]});
      hi_r[j]   <= row[j] * $signed(adj[mi3_pkg::DET_ADJ[j]][AW-1:W]);
      term_r[j] <= (DW'(hi_r[j]) <<< W) + DW'(lo_r[j]);
    end
    det_r <= term_r[0] + term_r[1] + term_r[2];
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
      adj3_r[i] <= adj[i];
      adj4_r[i] <= adj3_r[i];
      adj5_r[i] <= adj4_r[i];
    end
  end

  assign out_valid = v5_r;
  assign adj_out   = adj5_r;
  assign det       = det_r;

endmodule

// ===== rtl/mi3_divider.sv =====
// ----------------------------------------------------------------------------
// mi3_divider
// Nine-lane pipelined restoring divider: magnitude stage, overflow check,
// one quotient bit per stage, then saturation and sign restore.
// ----------------------------------------------------------------------------
module mi3_divider #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [2*W:0]   adj [mi3_pkg::NUM_ELEM],
  input  logic signed [3*W+2:0] det,
  output logic                  out_valid,
  output logic signed [W-1:0]   res [mi3_pkg::NUM_ELEM],
  output logic                  singular,
  output logic                  clipped
);

  localparam int AW = 2 * W + 1;
  localparam int PW = 2 * W;
  localparam int DW = 3 * W + 3;
  localparam int NW = 2 * W + 2 * F;
  localparam int CW = (NW > DW + W) ? NW : DW + W;
  localparam int NE = mi3_pkg::NUM_ELEM;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  // magnitude stage
  logic              va_r, sa_r;
  logic [DW-1:0]     da_r;
  logic [NE-1:0]     nega_r;
  logic [NW-1:0]     na_r [NE];
  logic [AW-1:0]     amag [NE];
  logic [DW-1:0]     dmag;

  always_comb begin
    dmag = det[DW-1] ? DW'(-det) : DW'(det);
    for (int i = 0; i < NE; i++) begin
      amag[i] = adj[i][AW-1] ? AW'(-adj[i]) : AW'(adj[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= (det == '0);
    da_r <= dmag;
    for (int i = 0; i < NE; i++) begin
      nega_r[i] <= adj[i][AW-1] ^ det[DW-1];
      na_r[i]   <= NW'(amag[i][PW-1:0]) << (2 * F);
    end
  end

  // stage 0 checks quotient >= 2^W, stages 1..W each resolve one bit
  logic          v_r   [W+1];
  logic          s_r   [W+1];
  logic [DW-1:0] d_r   [W+1];
  logic [NE-1:0] neg_r [W+1];
  logic [NE-1:0] ov_r  [W+1];
  logic [NW-1:0] rem_r [W+1][NE];
  logic [W-1:0]  q_r   [W+1][NE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    s_r[0]   <= sa_r;
    d_r[0]   <= da_r;
    neg_r[0] <= nega_r;
    for (int i = 0; i < NE; i++) begin
      ov_r[0][i]  <= CW'(na_r[i]) >= (CW'(da_r) << W);
      rem_r[0][i] <= na_r[i];
      q_r[0][i]   <= '0;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    localparam int K = W - s;
    logic [CW-1:0] dsh;
    assign dsh = CW'(d_r[s-1]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      s_r[s]   <= s_r[s-1];
      d_r[s]   <= d_r[s-1];
      neg_r[s] <= neg_r[s-1];
      ov_r[s]  <= ov_r[s-1];
      for (int i = 0; i < NE; i++) begin
        if (CW'(rem_r[s-1][i]) >= dsh) begin
          rem_r[s][i]  <= NW'(CW'(rem_r[s-1][i]) - dsh);
          q_r[s][i]    <= q_r[s-1][i] | (W'(1) << K);
        end else begin
          rem_r[s][i]  <= rem_r[s-1][i];
          q_r[s][i]    <= q_r[s-1][i];
        end
      end
    end
  end

  // saturate and restore sign
  logic                vo_r, so_r, co_r;
  logic signed [W-1:0] res_r [NE];
  logic [W-1:0]        lim   [NE];
  logic [W-1:0]        mag   [NE];
  logic [NE-1:0]       sat;

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      lim[i] = neg_r[W][i] ? LIM_NEG : LIM_POS;
      sat[i] = ov_r[W][i] || (q_r[W][i] > lim[i]);
      mag[i] = sat[i] ? lim[i] : q_r[W][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    so_r <= s_r[W];
    co_r <= !s_r[W] && (|sat);
    for (int i = 0; i < NE; i++) begin
      if (s_r[W]) begin
        res_r[i] <= '0;
      end else if (neg_r[W][i]) begin
        res_r[i] <= -$signed(mag[i]);
      end else begin
        res_r[i] <= $signed(mag[i]);
      end
    end
  end

  assign out_valid = vo_r;
  assign res       = res_r;
  assign singular  = so_r;
  assign clipped   = co_r;

endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 inverse by the adjugate in signed fixed point, truncated and saturated.
//
//   channel   ports                        handshake
//   input     in_a00..in_a22               start && !busy
//   result    out_r00..r22, singular,      out_valid strobe, one cycle
//             clipped
//
// One word enters per cycle; busy is always low.
// Pipeline stages: 2 cofactor, 3 determinant, 1 magnitude,
// 1 overflow check, DATA_WIDTH quotient bits, 1 saturation.
// Synchronous active-low reset clears the valid pipe only.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_a00,
  input  logic signed [DATA_WIDTH-1:0] in_a01,
  input  logic signed [DATA_WIDTH-1:0] in_a02,
  input  logic signed [DATA_WIDTH-1:0] in_a10,
  input  logic signed [DATA_WIDTH-1:0] in_a11,
  input  logic signed [DATA_WIDTH-1:0] in_a12,
  input  logic signed [DATA_WIDTH-1:0] in_a20,
  input  logic signed [DATA_WIDTH-1:0] in_a21,
  input  logic signed [DATA_WIDTH-1:0] in_a22,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_r00,
  output logic signed [DATA_WIDTH-1:0] out_r01,
  output logic signed [DATA_WIDTH-1:0] out_r02,
  output logic signed [DATA_WIDTH-1:0] out_r10,
  output logic signed [DATA_WIDTH-1:0] out_r11,
  output logic signed [DATA_WIDTH-1:0] out_r12,
  output logic signed [DATA_WIDTH-1:0] out_r20,
  output logic signed [DATA_WIDTH-1:0] out_r21,
  output logic signed [DATA_WIDTH-1:0] out_r22,
  output logic                         out_singular,
  output logic                         out_clipped
);

  localparam int W = DATA_WIDTH;

  logic signed [W-1:0]   a_in  [mi3_pkg::NUM_ELEM];
  logic signed [2*W:0]   adj_c [mi3_pkg::NUM_ELEM];
  logic signed [2*W:0]   adj_d [mi3_pkg::NUM_ELEM];
  logic signed [W-1:0]   row_c [mi3_pkg::NUM_COL];
  logic signed [3*W+2:0] det_d;
  logic signed [W-1:0]   res   [mi3_pkg::NUM_ELEM];
  logic                  v_c, v_d, accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a_in[0] = in_a00;
  assign a_in[1] = in_a01;
  assign a_in[2] = in_a02;
  assign a_in[3] = in_a10;
  assign a_in[4] = in_a11;
  assign a_in[5] = in_a12;
  assign a_in[6] = in_a20;
  assign a_in[7] = in_a21;
  assign a_in[8] = in_a22;

  mi3_cofactor #(.W(W)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .a         (a_in),
    .out_valid (v_c),
    .adj       (adj_c),
    .row       (row_c)
  );

  mi3_det #(.W(W)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c),
    .adj       (adj_c),
    .row       (row_c),
    .out_valid (v_d),
    .adj_out   (adj_d),
    .det       (det_d)
  );

  mi3_divider #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_d),
    .adj       (adj_d),
    .det       (det_d),
    .out_valid (out_valid),
    .res       (res),
    .singular  (out_singular),
    .clipped   (out_clipped)
  );

  assign out_r00 = res[0];
  assign out_r01 = res[1];
  assign out_r02 = res[2];
  assign out_r10 = res[3];
  assign out_r11 = res[4];
  assign out_r12 = res[5];
  assign out_r20 = res[6];
  assign out_r21 = res[7];
  assign out_r22 = res[8];

endmodule

// ===== rtl/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the matrix inverse: busy never high, fixed latency, singular words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mi3_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_r00,
  input logic [DATA_WIDTH-1:0] out_r11,
  input logic [DATA_WIDTH-1:0] out_r22,
  input logic                  out_singular,
  input logic                  out_clipped
);

  localparam int LAT = DATA_WIDTH + 8;

  `MI3_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  `MI3_ASSERT_IMPL(a_latency, clk, rst_n, out_valid, $past(start && !busy, LAT))
  `MI3_ASSERT_IMPL(a_sing_noclip, clk, rst_n, out_valid && out_singular, !out_clipped)
  `MI3_ASSERT_IMPL(a_sing_zero, clk, rst_n, out_valid && out_singular,
    (out_r00 == '0) && (out_r11 == '0) && (out_r22 == '0))

endmodule

bind matrix_inverse_3x3 mi3_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_r00      (out_r00),
  .out_r11      (out_r11),
  .out_r22      (out_r22),
  .out_singular (out_singular),
  .out_clipped  (out_clipped)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the 3x3 fixed-point matrix inverse against a predictor of its own.
// Directed matrices come first: identity, extremes, singular and clipping
// cases. Random matrices follow in phases with varying sender idling, and
// every output word is compared field by field with the predicted inverse.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int LATENCY = DW + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [DW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [DW-1:0] EMAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] EMIN = 32'sh8000_0000;

  typedef logic signed [DW-1:0] elem_t;
  typedef elem_t mat_t [9];
  typedef struct {
    elem_t r [9];
    logic singular;
    logic clipped;
  } inv_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  elem_t a [9];
  logic out_valid, out_singular, out_clipped;
  elem_t r [9];

  mat_t pending_mats [$];
  inv_t inverse_q [$];
  int idle_pct = 0;
  int cycles = 0;
  bit failed = 1'b0;

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < 9; i++) a[i] = '0;
  end

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a00(a[0]), .in_a01(a[1]), .in_a02(a[2]),
    .in_a10(a[3]), .in_a11(a[4]), .in_a12(a[5]),
    .in_a20(a[6]), .in_a21(a[7]), .in_a22(a[8]),
    .out_valid(out_valid),
    .out_r00(r[0]), .out_r01(r[1]), .out_r02(r[2]),
    .out_r10(r[3]), .out_r11(r[4]), .out_r12(r[5]),
    .out_r20(r[6]), .out_r21(r[7]), .out_r22(r[8]),
    .out_singular(out_singular), .out_clipped(out_clipped)
  );

  function automatic inv_t invert_matrix(mat_t m);
    logic signed [127:0] x [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det, num;
    logic [127:0] nmag, dmag, q, lim;
    logic neg;
    inv_t res;
    for (int i = 0; i < 9; i++) x[i] = m[i];
    adj[0] = x[4]*x[8] - x[7]*x[5];
    adj[1] = x[2]*x[7] - x[1]*x[8];
    adj[2] = x[1]*x[5] - x[2]*x[4];
    adj[3] = x[5]*x[6] - x[3]*x[8];
    adj[4] = x[0]*x[8] - x[2]*x[6];
    adj[5] = x[3]*x[2] - x[0]*x[5];
    adj[6] = x[3]*x[7] - x[6]*x[4];
    adj[7] = x[6]*x[1] - x[0]*x[7];
    adj[8] = x[0]*x[4] - x[3]*x[1];
    det = x[0]*adj[0] + x[1]*adj[3] + x[2]*adj[6];
    res.singular = (det == 0);
    res.clipped = 1'b0;
    for (int i = 0; i < 9; i++) res.r[i] = '0;
    if (det != 0) begin
      dmag = det < 0 ? -det : det;
      for (int i = 0; i < 9; i++) begin
        num = adj[i] <<< 32;
        nmag = num < 0 ? -num : num;
        neg = (adj[i] < 0) ^ (det < 0);
        q = nmag / dmag;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
          q = lim;
          res.clipped = 1'b1;
        end
        res.r[i] = neg ? -q[DW-1:0] : q[DW-1:0];
      end
    end
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && pending_mats.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      for (int i = 0; i < 9; i++) a[i] <= pending_mats[0][i];
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance and output monitor
  always @(posedge clk) begin
    inv_t exp_inv;
    mat_t m;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      if (start && !busy) begin
        for (int i = 0; i < 9; i++) m[i] = a[i];
        inverse_q.push_back(invert_matrix(m));
        void'(pending_mats.pop_front());
      end
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected output word", $time);
          failed = 1'b1;
        end else begin
          exp_inv = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (r[i] !== exp_inv.r[i]) begin
              $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       exp_inv.r[i], r[i]);
              failed = 1'b1;
            end
          if (out_singular !== exp_inv.singular) begin
            $display("%0t: singular expected %b actual %b", $time,
                     exp_inv.singular, out_singular);
            failed = 1'b1;
          end
          if (out_clipped !== exp_inv.clipped) begin
            $display("%0t: clipped expected %b actual %b", $time,
                     exp_inv.clipped, out_clipped);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(0, 2 * 65536 * 4)) - 4 * 65536);
      2: return $urandom_range(1) ? EMAX : EMIN;
      3: return elem_t'(int'($urandom_range(0, 64)) - 32);
      default: return '0;
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    int kind, mode, src, dst;
    mode = $urandom_range(9);
    kind = $urandom_range(3);
    for (int i = 0; i < 9; i++) begin
      if (mode <= 2) m[i] = rand_elem(0);
      else if (mode == 3) m[i] = rand_elem($urandom_range(4));
      else m[i] = rand_elem(kind);
    end
    if (mode >= 5 && mode <= 6) begin
      // large diagonal, of magnitude 8 to 64 in Q16.16
      for (int i = 0; i < 9; i += 4)
        m[i] = elem_t'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(8, 64)) * 65536);
    end else if (mode == 7) begin
      // per element, copy from row src to row dst or from column src to column dst
      src = $urandom_range(2);
      dst = (src + 1 + $urandom_range(1)) % 3;
      for (int j = 0; j < 3; j++)
        if ($urandom_range(1)) m[dst*3+j] = m[src*3+j];
        else m[j*3+dst] = m[j*3+src];
    end
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_mats.size() > 0 || inverse_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    mat_t m;
    int pcts [4] = '{0, 75, 0, 36};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                 pending_mats.push_back(m);
    m = '{default: '0};                                      pending_mats.push_back(m);
    m = '{default: EMAX};                                    pending_mats.push_back(m);
    m = '{default: EMIN};                                    pending_mats.push_back(m);
    m = '{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX};               pending_mats.push_back(m);
    m = '{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN};               pending_mats.push_back(m);
    m = '{EMIN, 0, 0, 0, EMAX, 0, 0, 0, EMIN};               pending_mats.push_back(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                        pending_mats.push_back(m);
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                      pending_mats.push_back(m);
    m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};                  pending_mats.push_back(m);
    m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};               pending_mats.push_back(m);
    m = '{2*ONE, ONE, 0, ONE, 2*ONE, ONE, 0, ONE, 2*ONE};    pending_mats.push_back(m);
    m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE};
    pending_mats.push_back(m);
    m = '{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0};
    pending_mats.push_back(m);
    m = '{EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, 1, -1, EMAX};  pending_mats.push_back(m);
    m = '{EMIN, EMAX, 0, EMAX, EMIN, EMAX, 0, EMAX, EMIN};   pending_mats.push_back(m);
    m = '{ONE, 0, 0, 0, 1, 0, 0, 0, -1};                     pending_mats.push_back(m);
    m = '{-1, -1, 0, 0, 1, 0, 0, 0, 1};                      pending_mats.push_back(m);
    wait_drained();

    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      for (int n = 0; n < 150; n++) pending_mats.push_back(rand_matrix());
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && inverse_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
